// ===== rtl/harris_window_response_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef HARRIS_WINDOW_RESPONSE_UNIT_DEFINES_SVH
`define HARRIS_WINDOW_RESPONSE_UNIT_DEFINES_SVH

// checked only while out of reset
`define HWR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HWR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/hwr_pkg.sv =====
`timescale 1ns / 1ps
package hwr_pkg;

  localparam int unsigned MaxBlock   = 7;
  localparam int unsigned StoreRow   = MaxBlock + 2;
  localparam int unsigned StoreDepth = 2 * StoreRow;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);

  localparam int unsigned PixW    = 8;
  localparam int unsigned CntW    = 4;
  localparam int unsigned BlockW  = 3;
  localparam int unsigned KW      = 16;
  localparam int unsigned KFracW  = 16;
  localparam int unsigned GradW   = 11;
  localparam int unsigned ProdSW  = 2 * GradW;
  localparam int unsigned SumW    = 26;
  localparam int unsigned SumXyW  = 27;
  localparam int unsigned SW      = SumW + 1;
  localparam int unsigned S2W     = 2 * SW;
  localparam int unsigned HalfW   = S2W / 2;
  localparam int unsigned PartW   = KW + HalfW;
  localparam int unsigned AbW     = 2 * SumW;
  localparam int unsigned DetW    = 2 * SumXyW;
  localparam int unsigned RespW   = 55;
  localparam int unsigned RespXW  = RespW + 1;
  localparam int unsigned PenW    = RespW;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegBlockSize = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKCoef     = 1'b1;

  localparam logic [BlockW-1:0] BlockReset = 3'd7;
  localparam logic [KW-1:0]     KReset     = 16'd2621;

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [PixW-1:0] px;
    logic [CntW-1:0] col;
    logic            top_slot;
    logic            calc;
    logic            row_end;
    logic            win_end;
  } hwr_entry_t;

endpackage

// ===== rtl/hwr_fifo.sv =====
`timescale 1ns / 1ps
module hwr_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hwr_pkg::hwr_entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output hwr_pkg::hwr_entry_t entry_o
);

  hwr_pkg::hwr_entry_t slot_q [hwr_pkg::FifoDepth];
  logic [hwr_pkg::FifoAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hwr_pkg::FifoCntW-1:0] count_q;

  assign full_o  = (count_q == hwr_pkg::FifoCntW'(hwr_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == hwr_pkg::FifoAw'(hwr_pkg::FifoDepth - 1)) ? '0
                    : wr_ptr_q + hwr_pkg::FifoAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == hwr_pkg::FifoAw'(hwr_pkg::FifoDepth - 1)) ? '0
                    : rd_ptr_q + hwr_pkg::FifoAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + hwr_pkg::FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - hwr_pkg::FifoCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/hwr_front.sv =====
`timescale 1ns / 1ps
module hwr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hwr_pkg::PixW-1:0]   pixel_i,
  input  logic [hwr_pkg::BlockW-1:0] block_size_i,
  input  logic                       full_i,
  output logic                       push_o,
  output hwr_pkg::hwr_entry_t        entry_o
);

  logic [hwr_pkg::CntW-1:0] row_q, row_d, col_q, col_d;
  logic [hwr_pkg::CntW-1:0] bs_ext, last;
  logic                     row_end, win_end;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // last index of a row or column, block size clamped to 1..MaxBlock
  always_comb begin
    bs_ext = hwr_pkg::CntW'(block_size_i);
    if (bs_ext == '0) begin
      last = hwr_pkg::CntW'(2);
    end else if (bs_ext > hwr_pkg::CntW'(hwr_pkg::MaxBlock)) begin
      last = hwr_pkg::CntW'(hwr_pkg::MaxBlock + 1);
    end else begin
      last = bs_ext + hwr_pkg::CntW'(1);
    end
  end

  assign row_end = (col_q >= last);
  assign win_end = row_end && (row_q >= last);

  always_comb begin
    entry_o.px       = pixel_i;
    entry_o.col      = col_q;
    entry_o.top_slot = row_q[0];
    entry_o.calc     = (row_q >= hwr_pkg::CntW'(2)) && (col_q >= hwr_pkg::CntW'(2));
    entry_o.row_end  = row_end;
    entry_o.win_end  = win_end;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (win_end) begin
      row_d = '0;
      col_d = '0;
    end else if (row_end) begin
      row_d = row_q + hwr_pkg::CntW'(1);
      col_d = '0;
    end else begin
      col_d = col_q + hwr_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (push_o) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== rtl/hwr_back.sv =====
`timescale 1ns / 1ps
module hwr_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  hwr_pkg::hwr_entry_t              entry_i,
  output logic                             pop_o,
  input  logic [hwr_pkg::KW-1:0]           k_coef_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [hwr_pkg::RespW-1:0] response_o
);

  typedef enum logic [8:0] {
    StRead   = 9'b000000001,
    StExec   = 9'b000000010,
    StWrite1 = 9'b000000100,
    StWrite2 = 9'b000001000,
    StMul1   = 9'b000010000,
    StMul2   = 9'b000100000,
    StMul3   = 9'b001000000,
    StPen    = 9'b010000000,
    StResp   = 9'b100000000
  } hwr_back_state_e;

  hwr_back_state_e state_q, state_d;
  hwr_pkg::hwr_entry_t cur_q;

  // row store, two slots of StoreRow pixels
  logic [hwr_pkg::PixW-1:0]       store_q [hwr_pkg::StoreDepth];
  logic [hwr_pkg::StoreDepth-1:0] store_vld_q;
  logic [hwr_pkg::PixW-1:0]       top_rd_q, mid_rd_q;
  logic                           top_vld_q, mid_vld_q;
  logic                           rd_en;
  logic [hwr_pkg::StoreAw-1:0]    top_raddr, mid_raddr;
  logic                           mem_we;
  logic [hwr_pkg::CntW-1:0]       wcol;
  logic [hwr_pkg::StoreAw-1:0]    mem_waddr;
  logic [hwr_pkg::PixW-1:0]       mem_wdata;

  // columns c-1 and c-2 of the two stored rows, and of the current row
  logic [hwr_pkg::PixW-1:0] top_w_q [2];
  logic [hwr_pkg::PixW-1:0] mid_w_q [2];
  logic [hwr_pkg::PixW-1:0] taps_q  [2];
  logic [hwr_pkg::PixW-1:0] p0r, p1r;

  logic signed [hwr_pkg::GradW-1:0]  ix, iy;
  logic signed [hwr_pkg::ProdSW-1:0] pxx, pyy, pxy;

  logic [hwr_pkg::SumW-1:0]          sum_xx_q, sum_xx_d, sum_yy_q, sum_yy_d;
  logic signed [hwr_pkg::SumXyW-1:0] sum_xy_q, sum_xy_d;

  logic [hwr_pkg::AbW-1:0]          ab_q;
  logic signed [hwr_pkg::DetW-1:0]  cc_q, det_q;
  logic [hwr_pkg::SW-1:0]           s_q;
  logic [hwr_pkg::S2W-1:0]          s2_q;
  logic [hwr_pkg::PartW-1:0]        plo_q, phi_q;
  logic [hwr_pkg::PenW-1:0]         pen_q;
  logic signed [hwr_pkg::RespXW-1:0] resp_full;
  logic                             out_load, out_valid_q;
  logic signed [hwr_pkg::RespW-1:0] response_q;

  function automatic logic [hwr_pkg::StoreAw-1:0] store_addr(
    input logic                     slot,
    input logic [hwr_pkg::CntW-1:0] col
  );
    return slot ? hwr_pkg::StoreAw'(hwr_pkg::StoreRow) + hwr_pkg::StoreAw'(col)
                : hwr_pkg::StoreAw'(col);
  endfunction

  function automatic logic signed [hwr_pkg::GradW-1:0] ext(input logic [hwr_pkg::PixW-1:0] v);
    return $signed({{(hwr_pkg::GradW - hwr_pkg::PixW){1'b0}}, v});
  endfunction

  assign rd_en     = (state_q == StRead) && !empty_i;
  assign pop_o     = rd_en;
  assign top_raddr = store_addr(entry_i.top_slot, entry_i.col);
  assign mid_raddr = store_addr(!entry_i.top_slot, entry_i.col);
  assign out_load  = (state_q == StResp) && (!out_valid_q || out_ready_i);

  // unwritten store entries read as zero
  assign p0r = top_vld_q ? top_rd_q : '0;
  assign p1r = mid_vld_q ? mid_rd_q : '0;

  // 3x3 sobel at the current column
  always_comb begin
    ix = ((ext(p1r) - ext(mid_w_q[1])) <<< 1) + (ext(p0r) - ext(top_w_q[1]))
         + (ext(cur_q.px) - ext(taps_q[1]));
    iy = ((ext(taps_q[0]) - ext(top_w_q[0])) <<< 1) + (ext(taps_q[1]) - ext(top_w_q[1]))
         + (ext(cur_q.px) - ext(p0r));
    pxx = ix * ix;
    pyy = iy * iy;
    pxy = ix * iy;
  end

  always_comb begin
    sum_xx_d = sum_xx_q;
    sum_yy_d = sum_yy_q;
    sum_xy_d = sum_xy_q;
    if (state_q == StExec && cur_q.calc) begin
      sum_xx_d = sum_xx_q + hwr_pkg::SumW'($unsigned(pxx));
      sum_yy_d = sum_yy_q + hwr_pkg::SumW'($unsigned(pyy));
      sum_xy_d = sum_xy_q + hwr_pkg::SumXyW'(pxy);
    end else if (out_load) begin
      sum_xx_d = '0;
      sum_yy_d = '0;
      sum_xy_d = '0;
    end
  end

  // sequencer and store writes into the top slot
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    wcol      = cur_q.col;
    mem_wdata = taps_q[0];
    unique case (state_q)
      StRead: begin
        if (!empty_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        mem_we    = (cur_q.col >= hwr_pkg::CntW'(2));
        wcol      = cur_q.col - hwr_pkg::CntW'(2);
        mem_wdata = taps_q[1];
        state_d   = cur_q.row_end ? StWrite1 : StRead;
      end
      StWrite1: begin
        // taps have shifted: taps_q[1] holds the pixel of column c-1
        mem_we    = (cur_q.col >= hwr_pkg::CntW'(1));
        wcol      = cur_q.col - hwr_pkg::CntW'(1);
        mem_wdata = taps_q[1];
        state_d   = StWrite2;
      end
      StWrite2: begin
        mem_we    = 1'b1;
        wcol      = cur_q.col;
        mem_wdata = taps_q[0];
        state_d   = cur_q.win_end ? StMul1 : StRead;
      end
      StMul1: state_d = StMul2;
      StMul2: state_d = StMul3;
      StMul3: state_d = StPen;
      StPen:  state_d = StResp;
      StResp: begin
        if (out_load) begin
          state_d = StRead;
        end
      end
      default: state_d = StRead;
    endcase
  end

  assign mem_waddr = store_addr(cur_q.top_slot, wcol);

  // response: a*b - c*c - floor(k*(a+b)^2 / 2^16); c*c <= a*b keeps it in range
  assign resp_full = hwr_pkg::RespXW'(det_q) - $signed(hwr_pkg::RespXW'(pen_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRead;
      store_vld_q <= '0;
      top_vld_q   <= 1'b0;
      mid_vld_q   <= 1'b0;
      taps_q[0]   <= '0;
      taps_q[1]   <= '0;
      sum_xx_q    <= '0;
      sum_yy_q    <= '0;
      sum_xy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_xx_q <= sum_xx_d;
      sum_yy_q <= sum_yy_d;
      sum_xy_q <= sum_xy_d;
      if (mem_we) begin
        store_vld_q[mem_waddr] <= 1'b1;
      end
      if (rd_en) begin
        top_vld_q <= store_vld_q[top_raddr];
        mid_vld_q <= store_vld_q[mid_raddr];
      end
      if (state_q == StExec) begin
        taps_q[1] <= taps_q[0];
        taps_q[0] <= cur_q.px;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      cur_q    <= entry_i;
      top_rd_q <= store_q[top_raddr];
      mid_rd_q <= store_q[mid_raddr];
    end
    if (state_q == StExec) begin
      top_w_q[1] <= top_w_q[0];
      top_w_q[0] <= p0r;
      mid_w_q[1] <= mid_w_q[0];
      mid_w_q[0] <= p1r;
    end
    if (state_q == StMul1) begin
      ab_q <= sum_xx_q * sum_yy_q;
      cc_q <= sum_xy_q * sum_xy_q;
      s_q  <= hwr_pkg::SW'(sum_xx_q) + hwr_pkg::SW'(sum_yy_q);
    end
    if (state_q == StMul2) begin
      s2_q  <= s_q * s_q;
      det_q <= $signed(hwr_pkg::DetW'(ab_q)) - cc_q;
    end
    if (state_q == StMul3) begin
      plo_q <= k_coef_i * s2_q[hwr_pkg::HalfW-1:0];
      phi_q <= k_coef_i * s2_q[hwr_pkg::S2W-1:hwr_pkg::HalfW];
    end
    if (state_q == StPen) begin
      pen_q <= (hwr_pkg::PenW'(phi_q) << (hwr_pkg::HalfW - hwr_pkg::KFracW))
               + hwr_pkg::PenW'(plo_q >> hwr_pkg::KFracW);
    end
    if (out_load) begin
      response_q <= $signed(resp_full[hwr_pkg::RespW-1:0]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign response_o  = response_q;

endmodule

// ===== rtl/harris_window_response_unit.sv =====
`timescale 1ns / 1ps
// Harris corner response over one keypoint window. Pixels of the padded
// (B+2)x(B+2) window stream in row-major order, one per transfer; after the
// last pixel of a window one signed 55-bit response (the common scale^4
// factor left out) is transferred on the output. The front end counts rows
// and columns and tags each pixel; a two-entry queue hands the tags to the
// back end, which reads the row store for each pixel and then runs sobel
// and accumulate, at each row end finishes writing the row store through
// its single write port, and at the window end runs the response
// multiplies. The input keeps taking pixels until the queue fills. The
// output register lets the back end go on with the next window while a
// result waits. Registers: index 0 block_size (B, 0 acts as 1), index 1
// k coefficient (Q0.16); write them only while no pixel or result is in
// flight, cfg_ready_o is always high.
module harris_window_response_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [hwr_pkg::PixW-1:0]          pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [hwr_pkg::RespW-1:0]  response_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hwr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hwr_pkg::CfgDataW-1:0]      cfg_data_i
);

  // configuration registers
  logic [hwr_pkg::BlockW-1:0] block_size_q;
  logic [hwr_pkg::KW-1:0]     k_coef_q;

  // front to queue
  logic                push;
  logic                full;
  hwr_pkg::hwr_entry_t front_entry;

  // queue to back
  logic                pop;
  logic                empty;
  hwr_pkg::hwr_entry_t back_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= hwr_pkg::BlockReset;
      k_coef_q     <= hwr_pkg::KReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hwr_pkg::RegBlockSize: block_size_q <= cfg_data_i[hwr_pkg::BlockW-1:0];
        hwr_pkg::RegKCoef:     k_coef_q     <= cfg_data_i[hwr_pkg::KW-1:0];
        default: ;
      endcase
    end
  end

  // position tracking and tagging of each pixel transfer
  hwr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .block_size_i (block_size_q),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (front_entry)
  );

  // short queue so front and back stall independently
  hwr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (back_entry)
  );

  // row store, gradients, sums and the response
  hwr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (back_entry),
    .pop_o       (pop),
    .k_coef_i    (k_coef_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .response_o  (response_o)
  );

endmodule

// ===== rtl/hwr_checker.sv =====
`timescale 1ns / 1ps
`include "harris_window_response_unit_defines.svh"
module hwr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [hwr_pkg::RespW-1:0] response_o,
  input logic                             cfg_ready_o
);

  // a stalled result holds
  `HWR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(response_o), "result dropped or changed while stalled")

  // no result while in reset
  `HWR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

  // the queue only fills on a pixel transfer
  `HWR_ASSERT(a_ready_drop, $fell(in_ready_o) |-> $past(in_valid_i), "input ready fell without a transfer")

  // register writes are never stalled
  `HWR_ASSERT(a_cfg_ready, cfg_ready_o, "config port not ready")

endmodule

bind harris_window_response_unit hwr_checker u_hwr_checker (.*);
